### src/rational_arithmetic_unit_macros.svh
// ---------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared assertion forms for the rational arithmetic unit
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

### src/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// operation codes and result limits of the rational arithmetic unit
// ---------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4
    } action_t;

    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 62;

    localparam logic [63:0] NUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NUM_NEG_MAX = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DEN_MAX     = 64'h3FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

### src/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational arithmetic unit
// add, subtract, multiply, divide or compare two signed fractions, result
// reduced to lowest terms
// ---------------------------------------------------------------------------
// usage
//   input channel  in_valid/in_ready carries action and the two fractions
//   output channel out_valid/out_ready carries the reduced result and flags
//   in_ready is high only while the sequencer is idle; one item at a time
//   steps in order: products on one shared multiplier, combine, the binary
//   gcd loop (one subtract or shift a cycle), two restoring divisions on one
//   shared subtractor, then the output register is loaded; compare and zero
//   results skip gcd and divisions; in_ready returns with out_valid
//   on a receiver stall the sequencer waits in its last state until the
//   result register is free; reset clears the sequencer and drops out_valid
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] a_num,
    input  wire logic signed [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic signed [31:0] b_den,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      res_num,
    output logic [61:0]             res_den,
    output logic                    less,
    output logic                    equal,
    output logic                    greater,
    output logic                    zero_den_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(PW);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_COMB = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIVM = 7'b0010000,
        ST_DIVD = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        mcnt_reg, mcnt_next;
    logic [CW-1:0]     dcnt_reg, dcnt_next;

    rau_pkg::action_t  act_reg, act_next;
    logic              a_neg_reg, a_neg_next, b_neg_reg, b_neg_next;
    logic [W-1:0]      a_mag_reg, a_mag_next, a_den_reg, a_den_next;
    logic [W-1:0]      b_mag_reg, b_mag_next, b_den_reg, b_den_next;
    logic              zflag_reg, zflag_next;
    logic [PW-1:0]     p1_reg, p1_next, p2_reg, p2_next, p3_reg, p3_next;
    logic              neg_reg, neg_next;
    logic [PW-1:0]     u_reg, u_next, v_reg, v_next;
    logic [PW-1:0]     mq_reg, mq_next, dq_reg, dq_next;
    logic [PW-1:0]     rem_reg, rem_next;
    logic              lt_reg, lt_next, eq_reg, eq_next, gt_reg, gt_next;
    logic [63:0]       res_num_reg, res_num_next;
    logic [61:0]       res_den_reg, res_den_next;
    logic              less_reg, less_next, equal_reg, equal_next;
    logic              greater_reg, greater_next, zde_reg, zde_next;

    // operand normalisation
    logic [W-1:0] an_abs, ad_abs, bn_abs, bd_abs;
    logic         a_dz, b_dz;

    // shared multiplier
    logic [W-1:0]  mx, my;
    logic [PW-1:0] prod;

    // combine
    logic [PW-1:0] c_mag, c_den;
    logic          c_neg, c_lt, c_eq, c_gt, c_z, s2;

    // gcd and divider
    logic [PW-1:0] g_diff, dvd;
    logic [PW:0]   rem_sh, d_diff;
    logic          q_bit;

    // output saturation
    logic [63:0]   magx, num_sat, denx, den_sat;

    assign an_abs = a_num[W-1] ? W'(-a_num[W-1:0]) : a_num[W-1:0];
    assign ad_abs = a_den[W-1] ? W'(-a_den[W-1:0]) : a_den[W-1:0];
    assign bn_abs = b_num[W-1] ? W'(-b_num[W-1:0]) : b_num[W-1:0];
    assign bd_abs = b_den[W-1] ? W'(-b_den[W-1:0]) : b_den[W-1:0];
    assign a_dz   = (a_den[W-1:0] == '0);
    assign b_dz   = (b_den[W-1:0] == '0);

    always_comb
    begin
        mx = a_mag_reg;
        my = b_den_reg;
        case (mcnt_reg)
            2'd0:
            begin
                mx = a_mag_reg;
                my = (act_reg == rau_pkg::ACT_MUL) ? b_mag_reg : b_den_reg;
            end
            2'd1:
            begin
                mx = b_mag_reg;
                my = a_den_reg;
            end
            default:
            begin
                mx = a_den_reg;
                my = (act_reg == rau_pkg::ACT_DIV) ? b_mag_reg : b_den_reg;
            end
        endcase
    end

    assign prod = mx * my;

    always_comb
    begin
        c_mag = '0;
        c_den = PW'(1);
        c_neg = 1'b0;
        c_lt  = 1'b0;
        c_eq  = 1'b0;
        c_gt  = 1'b0;
        c_z   = zflag_reg;
        s2    = b_neg_reg;
        case (act_reg)
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB:
            begin
                s2 = (act_reg == rau_pkg::ACT_SUB) ? !b_neg_reg : b_neg_reg;
                if (p2_reg == '0)
                    s2 = a_neg_reg;
                if (a_neg_reg == s2)
                begin
                    c_mag = p1_reg + p2_reg;
                    c_neg = a_neg_reg;
                end
                else if (p1_reg >= p2_reg)
                begin
                    c_mag = p1_reg - p2_reg;
                    c_neg = a_neg_reg;
                end
                else
                begin
                    c_mag = p2_reg - p1_reg;
                    c_neg = s2;
                end
                c_den = p3_reg;
            end
            rau_pkg::ACT_MUL:
            begin
                c_mag = p1_reg;
                c_den = p3_reg;
                c_neg = a_neg_reg ^ b_neg_reg;
            end
            rau_pkg::ACT_DIV:
            begin
                c_mag = p1_reg;
                c_neg = a_neg_reg ^ b_neg_reg;
                c_den = p3_reg;
                if (p3_reg == '0)
                begin
                    c_den = PW'(1);
                    c_neg = a_neg_reg;
                    c_z   = 1'b1;
                end
            end
            rau_pkg::ACT_CMP:
            begin
                if (a_neg_reg != b_neg_reg)
                begin
                    c_lt = a_neg_reg;
                    c_gt = b_neg_reg;
                end
                else if (!a_neg_reg)
                begin
                    c_lt = p1_reg < p2_reg;
                    c_eq = p1_reg == p2_reg;
                    c_gt = p1_reg > p2_reg;
                end
                else
                begin
                    c_lt = p1_reg > p2_reg;
                    c_eq = p1_reg == p2_reg;
                    c_gt = p1_reg < p2_reg;
                end
            end
            default:
            begin
                c_mag = '0;
            end
        endcase
    end

    assign g_diff = (u_reg >= v_reg) ? (u_reg - v_reg) : (v_reg - u_reg);

    assign dvd    = (state_reg == ST_DIVM) ? mq_reg : dq_reg;
    assign rem_sh = {rem_reg, dvd[PW-1]};
    assign d_diff = rem_sh - {1'b0, v_reg};
    assign q_bit  = !d_diff[PW];

    assign magx    = 64'(mq_reg);
    assign denx    = 64'(dq_reg);
    assign num_sat = neg_reg ? ((magx > rau_pkg::NUM_NEG_MAX) ? rau_pkg::NUM_NEG_MAX : magx)
                             : ((magx > rau_pkg::NUM_POS_MAX) ? rau_pkg::NUM_POS_MAX : magx);
    assign den_sat = (denx > rau_pkg::DEN_MAX) ? rau_pkg::DEN_MAX : denx;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        mcnt_next      = mcnt_reg;
        dcnt_next      = dcnt_reg;
        act_next       = act_reg;
        a_neg_next     = a_neg_reg;
        b_neg_next     = b_neg_reg;
        a_mag_next     = a_mag_reg;
        a_den_next     = a_den_reg;
        b_mag_next     = b_mag_reg;
        b_den_next     = b_den_reg;
        zflag_next     = zflag_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        mq_next        = mq_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        lt_next        = lt_reg;
        eq_next        = eq_reg;
        gt_next        = gt_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        less_next      = less_reg;
        equal_next     = equal_reg;
        greater_next   = greater_reg;
        zde_next       = zde_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = rau_pkg::action_t'(action);
                    a_mag_next = an_abs;
                    b_mag_next = bn_abs;
                    a_den_next = a_dz ? W'(1) : ad_abs;
                    b_den_next = b_dz ? W'(1) : bd_abs;
                    a_neg_next = (an_abs != '0) && (a_num[W-1] ^ a_den[W-1]);
                    b_neg_next = (bn_abs != '0) && (b_num[W-1] ^ b_den[W-1]);
                    zflag_next = a_dz || b_dz;
                    mcnt_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                case (mcnt_reg)
                    2'd0:    p1_next = prod;
                    2'd1:    p2_next = prod;
                    default: p3_next = prod;
                endcase
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2)
                    state_next = ST_COMB;
            end
            ST_COMB:
            begin
                lt_next    = c_lt;
                eq_next    = c_eq;
                gt_next    = c_gt;
                zflag_next = c_z;
                if (c_mag == '0)
                begin
                    neg_next   = 1'b0;
                    mq_next    = '0;
                    dq_next    = PW'(1);
                    state_next = ST_OUT;
                end
                else
                begin
                    neg_next   = c_neg;
                    u_next     = c_mag;
                    v_next     = c_den;
                    mq_next    = c_mag;
                    dq_next    = c_den;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (u_reg == '0)
                begin
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIVM;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next  = u_reg >> 1;
                    v_next  = v_reg >> 1;
                    mq_next = mq_reg >> 1;
                    dq_next = dq_reg >> 1;
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_next = g_diff;
                else
                    v_next = g_diff;
            end
            ST_DIVM, ST_DIVD:
            begin
                rem_next  = q_bit ? d_diff[PW-1:0] : rem_sh[PW-1:0];
                dcnt_next = dcnt_reg + CW'(1);
                if (state_reg == ST_DIVM)
                    mq_next = {mq_reg[PW-2:0], q_bit};
                else
                    dq_next = {dq_reg[PW-2:0], q_bit};
                if (dcnt_reg == CW'(PW - 1))
                begin
                    dcnt_next  = '0;
                    rem_next   = '0;
                    state_next = (state_reg == ST_DIVM) ? ST_DIVD : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_num_next   = neg_reg ? (~num_sat + 64'd1) : num_sat;
                    res_den_next   = den_sat[61:0];
                    less_next      = lt_reg;
                    equal_next     = eq_reg;
                    greater_next   = gt_reg;
                    zde_next       = zflag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mcnt_reg      <= mcnt_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        a_neg_reg   <= a_neg_next;
        b_neg_reg   <= b_neg_next;
        a_mag_reg   <= a_mag_next;
        a_den_reg   <= a_den_next;
        b_mag_reg   <= b_mag_next;
        b_den_reg   <= b_den_next;
        zflag_reg   <= zflag_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p3_reg      <= p3_next;
        neg_reg     <= neg_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        mq_reg      <= mq_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        lt_reg      <= lt_next;
        eq_reg      <= eq_next;
        gt_reg      <= gt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        less_reg    <= less_next;
        equal_reg   <= equal_next;
        greater_reg <= greater_next;
        zde_reg     <= zde_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign res_num        = res_num_reg;
    assign res_den        = res_den_reg;
    assign less           = less_reg;
    assign equal          = equal_reg;
    assign greater        = greater_reg;
    assign zero_den_error = zde_reg;

`include "rational_arithmetic_unit_macros.svh"

    `RAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `RAU_ASSERT_NOW(a_den_nonzero, clk, rst_n, out_valid, res_den != '0)
    `RAU_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_valid, $onehot0({less, equal, greater}))
    `RAU_ASSERT_NOW(a_gcd_divisor_live, clk, rst_n, state_reg == ST_GCD, v_reg != '0)

endmodule

`default_nettype wire

### verif/rational_arithmetic_unit_tb.sv
// ---------------------------------------------------------------------------
// rational arithmetic unit testbench
// drives fraction pairs with every operation through the valid/ready input,
// predicts each reduced result and compares it with what the unit returns
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int RANDOM_ITEMS   = 1500;
    localparam logic signed [31:0] OP_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] OP_MAX = 32'sh7FFF_FFFF;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         act;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
    } frac_pair_t;

    typedef struct packed {
        logic signed [63:0] num;
        logic [61:0]        den;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               zden;
    } frac_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         action = rau_pkg::ACT_ADD;
    logic signed [31:0] a_num = '0;
    logic signed [31:0] a_den = '0;
    logic signed [31:0] b_num = '0;
    logic signed [31:0] b_den = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] res_num;
    logic [61:0]        res_den;
    logic               less;
    logic               equal;
    logic               greater;
    logic               zero_den_error;

    frac_pair_t   pending_pairs[$];
    frac_result_t expected_results[$];
    int           accepted_pairs = 0;
    int           total_pairs = 0;
    int           idle_cycles = 0;
    int           fail_count = 0;
    bit           in_took = 1'b0;

    always #4 clk = ~clk;

    rational_arithmetic_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .res_num        (res_num),
        .res_den        (res_den),
        .less           (less),
        .equal          (equal),
        .greater        (greater),
        .zero_den_error (zero_den_error)
    );

    function automatic void normalise_frac(input logic signed [31:0] n,
                                           input logic signed [31:0] d,
                                           inout bit zden,
                                           output longint snum,
                                           output longint unsigned mag,
                                           output longint unsigned den);
        longint sn;
        longint sd;
        sn = n;
        sd = d;
        if (sd < 0)
        begin
            sn = -sn;
            sd = -sd;
        end
        else if (sd == 0)
        begin
            sd = 1;
            zden = 1'b1;
        end
        snum = sn;
        mag  = (sn < 0) ? longint'(-sn) : sn;
        den  = sd;
    endfunction

    function automatic frac_result_t reduce_fractions(frac_pair_t p);
        frac_result_t      r;
        bit                zden;
        longint            asn;
        longint            bsn;
        longint unsigned   am;
        longint unsigned   ad;
        longint unsigned   bm;
        longint unsigned   bd;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   t1;
        longint unsigned   t2;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   t;
        longint            l;
        longint            rr;
        bit                neg;
        bit                s1;
        bit                s2;
        zden = 1'b0;
        normalise_frac(p.an, p.ad, zden, asn, am, ad);
        normalise_frac(p.bn, p.bd, zden, bsn, bm, bd);
        neg = 1'b0;
        mag = 0;
        den = 1;
        r   = '0;
        case (p.act)
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB:
            begin
                t1 = am * bd;
                t2 = bm * ad;
                s1 = asn < 0;
                s2 = (p.act == rau_pkg::ACT_SUB) ? !(bsn < 0) : (bsn < 0);
                if (t2 == 0)
                    s2 = s1;
                if (s1 == s2)
                begin
                    mag = t1 + t2;
                    neg = s1;
                end
                else if (t1 >= t2)
                begin
                    mag = t1 - t2;
                    neg = s1;
                end
                else
                begin
                    mag = t2 - t1;
                    neg = s2;
                end
                den = ad * bd;
            end
            rau_pkg::ACT_MUL:
            begin
                mag = am * bm;
                neg = (asn < 0) != (bsn < 0);
                den = ad * bd;
            end
            rau_pkg::ACT_DIV:
            begin
                mag = am * bd;
                den = ad * bm;
                neg = (asn < 0) != (bsn < 0);
                if (den == 0)
                begin
                    den  = 1;
                    neg  = asn < 0;
                    zden = 1'b1;
                end
            end
            rau_pkg::ACT_CMP:
            begin
                l    = asn * longint'(bd);
                rr   = bsn * longint'(ad);
                r.lt = l < rr;
                r.eq = l == rr;
                r.gt = l > rr;
            end
            default:
            begin
            end
        endcase
        if (mag == 0)
        begin
            neg = 1'b0;
            den = 1;
        end
        else
        begin
            x = mag;
            y = den;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            mag = mag / x;
            den = den / x;
        end
        if (neg)
        begin
            if (mag > rau_pkg::NUM_NEG_MAX)
                mag = rau_pkg::NUM_NEG_MAX;
            r.num = ~mag + 64'd1;
        end
        else
            r.num = (mag > rau_pkg::NUM_POS_MAX) ? rau_pkg::NUM_POS_MAX : mag;
        r.den  = (den > rau_pkg::DEN_MAX) ? rau_pkg::DEN_MAX[61:0] : den[61:0];
        r.zden = zden;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return OP_MIN;
            1: return OP_MAX;
            2: return 32'sd0;
            3, 4: return $signed(32'($urandom_range(0, 24))) - 32'sd12;
            5, 6: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_pair(logic [2:0] act, logic signed [31:0] an,
                              logic signed [31:0] ad, logic signed [31:0] bn,
                              logic signed [31:0] bd);
        frac_pair_t p;
        p.act = act;
        p.an  = an;
        p.ad  = ad;
        p.bn  = bn;
        p.bd  = bd;
        pending_pairs.push_back(p);
    endtask

    function automatic int sender_idle_pct();
        if (accepted_pairs < total_pairs / 3)
            return 22;
        if (accepted_pairs < 2 * total_pairs / 3)
            return 63;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_pairs < total_pairs / 3)
            return 63;
        if (accepted_pairs < 2 * total_pairs / 3)
            return 22;
        return 0;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    frac_pair_t p;
                    p = pending_pairs.pop_front();
                    action   <= p.act;
                    a_num    <= p.an;
                    a_den    <= p.ad;
                    b_num    <= p.bn;
                    b_den    <= p.bd;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= $urandom_range(0, 99) >= receiver_idle_pct();
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        frac_pair_t   p;
        frac_result_t got;
        frac_result_t exp_r;
        in_took = in_valid && in_ready;
        if (in_took)
        begin
            p.act = action;
            p.an  = a_num;
            p.ad  = a_den;
            p.bn  = b_num;
            p.bd  = b_den;
            expected_results.push_back(reduce_fractions(p));
            accepted_pairs++;
        end
        if (out_valid && out_ready)
        begin
            got.num  = res_num;
            got.den  = res_den;
            got.lt   = less;
            got.eq   = equal;
            got.gt   = greater;
            got.zden = zero_den_error;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: exp none act %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.num !== exp_r.num)
                    $display("%0t res_num: exp %h act %h", $time, exp_r.num, got.num);
                if (got.den !== exp_r.den)
                    $display("%0t res_den: exp %h act %h", $time, exp_r.den, got.den);
                if (got.lt !== exp_r.lt || got.eq !== exp_r.eq || got.gt !== exp_r.gt)
                    $display("%0t lt/eq/gt: exp %b%b%b act %b%b%b", $time,
                             exp_r.lt, exp_r.eq, exp_r.gt, got.lt, got.eq, got.gt);
                if (got.zden !== exp_r.zden)
                    $display("%0t zero_den_error: exp %b act %b", $time,
                             exp_r.zden, got.zden);
                if (got !== exp_r)
                    fail_count++;
            end
        end
        if (in_took || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] act;
        // extremes, every operation, zero denominators, divide by zero
        queue_pair(rau_pkg::ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        queue_pair(rau_pkg::ACT_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
        queue_pair(rau_pkg::ACT_MUL, -32'sd3, 32'sd4, 32'sd8, -32'sd9);
        queue_pair(rau_pkg::ACT_DIV, 32'sd3, 32'sd4, -32'sd6, 32'sd8);
        queue_pair(rau_pkg::ACT_CMP, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
        queue_pair(rau_pkg::ACT_CMP, -32'sd1, 32'sd2, 32'sd1, 32'sd3);
        queue_pair(rau_pkg::ACT_CMP, 32'sd5, -32'sd2, -32'sd1, 32'sd3);
        queue_pair(rau_pkg::ACT_ADD, 32'sd7, 32'sd0, 32'sd1, 32'sd0);
        queue_pair(rau_pkg::ACT_DIV, 32'sd5, 32'sd3, 32'sd0, 32'sd7);
        queue_pair(rau_pkg::ACT_DIV, -32'sd5, 32'sd3, 32'sd0, -32'sd7);
        queue_pair(rau_pkg::ACT_MUL, 32'sd0, 32'sd9, 32'sd4, 32'sd5);
        queue_pair(rau_pkg::ACT_ADD, OP_MAX, 32'sd1, OP_MAX, 32'sd1);
        queue_pair(rau_pkg::ACT_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
        queue_pair(rau_pkg::ACT_MUL, OP_MIN, -32'sd1, OP_MIN, -32'sd1);
        queue_pair(rau_pkg::ACT_MUL, 32'sd1, OP_MIN, -32'sd1, OP_MIN);
        queue_pair(rau_pkg::ACT_ADD, OP_MIN, OP_MAX, OP_MIN, 32'sd1);
        queue_pair(rau_pkg::ACT_ADD, OP_MIN, -32'sd1, OP_MIN, -32'sd1);
        queue_pair(rau_pkg::ACT_DIV, OP_MIN, 32'sd1, 32'sd1, OP_MIN);
        queue_pair(rau_pkg::ACT_DIV, OP_MAX, OP_MAX, OP_MIN, OP_MIN);
        queue_pair(rau_pkg::ACT_CMP, OP_MIN, 32'sd1, OP_MAX, 32'sd1);
        queue_pair(rau_pkg::ACT_CMP, OP_MAX, OP_MIN, OP_MIN, OP_MAX);
        queue_pair(rau_pkg::ACT_SUB, -32'sd4, 32'sd6, -32'sd2, 32'sd3);
        queue_pair(ACT_SPARE_LO, 32'sd3, 32'sd0, 32'sd1, 32'sd2);
        queue_pair(ACT_SPARE_HI, 32'sd3, 32'sd5, 32'sd1, 32'sd0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            else
                act = 3'($urandom_range(rau_pkg::ACT_ADD, rau_pkg::ACT_CMP));
            queue_pair(act, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
        total_pairs = pending_pairs.size();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
